/* hw/rtl/b64d_pkg.sv */
// Shared types, constants and the symbol lookup for the base64 stream decoder.
// Used by every module of the decoder; depends on nothing.
package b64d_pkg;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusBadChar = 2'd1;
  localparam logic [1:0] StatusBadLen  = 2'd2;
  localparam logic [1:0] StatusEmpty   = 2'd3;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam int JobDepth = 4;
  localparam int JobPtrW  = $clog2(JobDepth);

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_present;
    logic       message_end;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        fin;
    logic [1:0]  status;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sym_t;

  function automatic sym_t sym_lookup(input logic [7:0] c);
    sym_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    case (c) inside
      [8'h41:8'h5A]: s.value = 6'(c - 8'h41);
      [8'h61:8'h7A]: s.value = 6'(c - 8'h61 + 8'd26);
      [8'h30:8'h39]: s.value = 6'(c - 8'h30 + 8'd52);
      8'h2B:         s.value = 6'd62;
      8'h2F:         s.value = 6'd63;
      default:       s.valid = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h0D) || (c == 8'h0A) || (c == 8'h09) || (c == 8'h20);
  endfunction

endpackage

/* hw/rtl/base64_stream_decoder.sv */
// Top level of the base64 stream decoder: front end, job queue, back end.
// Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
//
// Usage:
//   Input channel: one raw character per beat on data_i, with is_final on the
//   last character of a message; a beat is taken when push is high and full
//   is low. CR, LF, tab and space are skipped.
//   Result channel: queue style; while empty is low, data_o holds the oldest
//   result, taken when pop is high. Each completed group of four symbols gives
//   three byte beats; the last beat of a message has message_end set and
//   carries the status (ok, bad character or pad, bad length, empty).
//   On a non-ok status, discard bytes already delivered for that message.
// Timing:
//   One character is accepted per cycle while full is low. The front end
//   classifies it in the cycle it is accepted and writes a job into a
//   four-entry queue; the back end drains one result beat per cycle into the
//   output register while it is empty or popped, so a character's first result
//   goes through a queue entry and then the output register. A character gives
//   at most one beat on average, so the back end keeps pace. If pop stays low
//   the output register and queue fill and full goes high.
// Reset: rst_ni clears all message state, empties the queue and marks the output register empty.
module base64_stream_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  b64d_pkg::in_t  data_i,
  output logic           empty,
  input  logic           pop,
  output b64d_pkg::out_t data_o
);

  logic           accept;
  logic           job_wr;
  logic           job_rd;
  logic           job_empty;
  b64d_pkg::job_t job_in;
  b64d_pkg::job_t job_out;

  assign accept = push && !full;

  b64d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .data_i   (data_i),
    .job_wr_o (job_wr),
    .job_o    (job_in)
  );

  b64d_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_wr),
    .wr_data_i (job_in),
    .full_o    (full),
    .rd_i      (job_rd),
    .rd_data_o (job_out),
    .empty_o   (job_empty)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_rd_o    (job_rd),
    .pop         (pop),
    .empty       (empty),
    .data_o      (data_o)
  );

endmodule

/* hw/rtl/b64d_front.sv */
// Front end: classifies each character, keeps the group state and builds jobs.
// Depends on b64d_pkg.
module b64d_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  b64d_pkg::in_t   data_i,
  output logic            job_wr_o,
  output b64d_pkg::job_t  job_o
);

  logic [17:0] group_q, group_d;
  logic [1:0]  fill_q, fill_d;
  logic        pad_q, pad_d;
  logic        err_q, err_d;
  logic        saw_q, saw_d;

  logic [23:0]      word;
  logic [1:0]       nb;
  logic [1:0]       status;
  logic             fin;
  b64d_pkg::sym_t   sym;

  assign fin = data_i.is_final;
  assign sym = b64d_pkg::sym_lookup(data_i.char_in);

  always_comb begin
    group_d = group_q;
    fill_d  = fill_q;
    pad_d   = pad_q;
    err_d   = err_q;
    saw_d   = saw_q;
    word    = 24'd0;
    nb      = 2'd0;
    if (!err_q) begin
      if (pad_q) begin
        if (data_i.char_in == b64d_pkg::PadChar && fin) begin
          if (fill_q == 2'd2) begin
            word   = {group_q[11:0], 12'd0};
            nb     = 2'd1;
            fill_d = 2'd0;
          end else begin
            fill_d = fill_q + 2'd2;
          end
        end else begin
          err_d = 1'b1;
        end
        pad_d = 1'b0;
      end else if (b64d_pkg::is_space(data_i.char_in)) begin
        err_d = err_q;
      end else if (data_i.char_in == b64d_pkg::PadChar) begin
        saw_d = 1'b1;
        if (fin) begin
          if (fill_q == 2'd3) begin
            word   = {group_q, 6'd0};
            nb     = 2'd2;
            fill_d = 2'd0;
          end else begin
            fill_d = fill_q + 2'd1;
          end
        end else begin
          pad_d = 1'b1;
        end
      end else if (sym.valid) begin
        saw_d = 1'b1;
        if (fill_q == 2'd3) begin
          word    = {group_q, sym.value};
          nb      = 2'd3;
          fill_d  = 2'd0;
          group_d = 18'd0;
        end else begin
          group_d = {group_q[11:0], sym.value};
          fill_d  = fill_q + 2'd1;
        end
      end else begin
        err_d = 1'b1;
      end
    end

    if (err_d) begin
      status = b64d_pkg::StatusBadChar;
    end else if (fill_d != 2'd0) begin
      status = b64d_pkg::StatusBadLen;
    end else if (!saw_d) begin
      status = b64d_pkg::StatusEmpty;
    end else begin
      status = b64d_pkg::StatusOk;
    end

    job_o.word   = word;
    job_o.fin    = fin;
    job_o.status = fin ? status : b64d_pkg::StatusOk;
    job_o.nbytes = (fin && status != b64d_pkg::StatusOk) ? 2'd0 : nb;
  end

  assign job_wr_o = accept_i && (fin || job_o.nbytes != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= 18'd0;
      fill_q  <= 2'd0;
      pad_q   <= 1'b0;
      err_q   <= 1'b0;
      saw_q   <= 1'b0;
    end else if (accept_i) begin
      if (fin) begin
        group_q <= 18'd0;
        fill_q  <= 2'd0;
        pad_q   <= 1'b0;
        err_q   <= 1'b0;
        saw_q   <= 1'b0;
      end else begin
        group_q <= group_d;
        fill_q  <= fill_d;
        pad_q   <= pad_d;
        err_q   <= err_d;
        saw_q   <= saw_d;
      end
    end
  end

endmodule

/* hw/rtl/b64d_fifo.sv */
// Short job queue between front end and back end.
// Depends on b64d_pkg for the job type and depth.
module b64d_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  b64d_pkg::job_t  wr_data_i,
  output logic            full_o,
  input  logic            rd_i,
  output b64d_pkg::job_t  rd_data_o,
  output logic            empty_o
);

  b64d_pkg::job_t mem_q [b64d_pkg::JobDepth];

  logic [b64d_pkg::JobPtrW-1:0] wptr_q, rptr_q;
  logic [b64d_pkg::JobPtrW:0]   count_q;
  logic                         do_wr, do_rd;

  assign full_o    = (count_q == (b64d_pkg::JobPtrW+1)'(b64d_pkg::JobDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* hw/rtl/b64d_back.sv */
// Back end: expands each job into result beats and holds the output register.
// Depends on b64d_pkg.
module b64d_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_empty_i,
  input  b64d_pkg::job_t  job_i,
  output logic            job_rd_o,
  input  logic            pop,
  output logic            empty,
  output b64d_pkg::out_t  data_o
);

  logic           out_valid_q;
  b64d_pkg::out_t out_q, out_d;
  logic [1:0]     idx_q;
  logic [1:0]     cnt;
  logic           last;
  logic           load;

  assign cnt  = (job_i.nbytes == 2'd0) ? 2'd1 : job_i.nbytes;
  assign last = (idx_q == cnt - 2'd1);
  assign load = !job_empty_i && (!out_valid_q || pop);

  assign job_rd_o = load && last;
  assign empty    = !out_valid_q;
  assign data_o   = out_q;

  always_comb begin
    case (idx_q)
      2'd0:    out_d.byte_out = job_i.word[23:16];
      2'd1:    out_d.byte_out = job_i.word[15:8];
      default: out_d.byte_out = job_i.word[7:0];
    endcase
    out_d.byte_present = (job_i.nbytes != 2'd0);
    if (!out_d.byte_present) begin
      out_d.byte_out = 8'd0;
    end
    out_d.message_end = job_i.fin && last;
    out_d.status      = out_d.message_end ? job_i.status : b64d_pkg::StatusOk;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 2'd0 : idx_q + 2'd1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/b64d_checker.sv */
// Port-level checker for the base64 stream decoder, bound to the top level.
// Depends on b64d_pkg and base64_stream_decoder.
module b64d_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty,
  input logic           pop,
  input b64d_pkg::out_t data_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(data_o)))
    else $error("result changed while stalled");

  a_no_byte_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !data_o.byte_present) |-> (data_o.message_end && data_o.byte_out == 8'd0))
    else $error("byte-free beat that does not end a message");

  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !data_o.message_end) |-> (data_o.status == b64d_pkg::StatusOk))
    else $error("status set on a beat that does not end a message");

  a_bytes_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && data_o.byte_present && data_o.message_end)
      |-> (data_o.status == b64d_pkg::StatusOk))
    else $error("byte beat carries an error status");

endmodule

bind base64_stream_decoder b64d_checker u_chk (.*);

/* bench/b64d_tb_pkg.sv */
// Scoreboard for the base64 stream decoder bench: predicts the result beats of
// every accepted character and checks the beats that the decoder delivers.
// Depends on b64d_pkg for the beat types, the pad character and the status codes.
package b64d_tb_pkg;
  import b64d_pkg::*;

  class b64_decode_scoreboard;
    logic [17:0] group_bits;
    logic [1:0]  group_count;
    logic        pad_open;
    logic        bad_seen;
    logic        any_symbol;
    out_t        expected_beats[$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear_message();
    endfunction

    function void clear_message();
      group_bits  = '0;
      group_count = '0;
      pad_open    = 1'b0;
      bad_seen    = 1'b0;
      any_symbol  = 1'b0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    static function int symbol_value(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
      if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
      if (c == 8'h2B) return 62;
      if (c == 8'h2F) return 63;
      return -1;
    endfunction

    static function logic is_blank(input logic [7:0] c);
      return (c == 8'h0D) || (c == 8'h0A) || (c == 8'h09) || (c == 8'h20);
    endfunction

    function void note_char(input in_t item);
      logic [23:0] w;
      logic [1:0]  code;
      int          nbytes;
      int          sym;
      int          k;
      out_t        beat;
      nbytes = 0;
      w      = '0;
      code   = StatusOk;
      if (!bad_seen) begin
        sym = symbol_value(item.char_in);
        if (pad_open) begin
          if (item.char_in == PadChar && item.is_final) begin
            if (group_count == 2'd2) begin
              w           = {group_bits[11:0], 12'd0};
              nbytes      = 1;
              group_count = 2'd0;
            end else begin
              group_count = group_count + 2'd2;
            end
          end else begin
            bad_seen = 1'b1;
          end
          pad_open = 1'b0;
        end else if (is_blank(item.char_in)) begin
          // skip blanks
        end else if (item.char_in == PadChar) begin
          any_symbol = 1'b1;
          if (!item.is_final) begin
            pad_open = 1'b1;
          end else if (group_count == 2'd3) begin
            w           = {group_bits, 6'd0};
            nbytes      = 2;
            group_count = 2'd0;
          end else begin
            group_count = group_count + 2'd1;
          end
        end else if (sym >= 0) begin
          any_symbol = 1'b1;
          if (group_count == 2'd3) begin
            w           = {group_bits, 6'(sym)};
            nbytes      = 3;
            group_count = 2'd0;
            group_bits  = '0;
          end else begin
            group_bits  = {group_bits[11:0], 6'(sym)};
            group_count = group_count + 2'd1;
          end
        end else begin
          bad_seen = 1'b1;
        end
      end

      if (item.is_final) begin
        if (bad_seen) code = StatusBadChar;
        else if (group_count != 2'd0) code = StatusBadLen;
        else if (!any_symbol) code = StatusEmpty;
        else code = StatusOk;
        if (code != StatusOk) nbytes = 0;
        clear_message();
        if (nbytes == 0) begin
          beat.byte_out     = 8'h00;
          beat.byte_present = 1'b0;
          beat.message_end  = 1'b1;
          beat.status       = code;
          expected_beats.push_back(beat);
        end
      end

      for (k = 0; k < nbytes; k++) begin
        beat.byte_out     = w[23 - 8 * k -: 8];
        beat.byte_present = 1'b1;
        beat.message_end  = item.is_final && (k == nbytes - 1);
        beat.status       = beat.message_end ? code : StatusOk;
        expected_beats.push_back(beat);
      end
    endfunction

    function void compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got, input time stamp);
      if (want !== got) begin
        $display("%0t: %s expected %0h, got %0h", stamp, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(input out_t got, input time stamp);
      out_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", stamp, got);
        mismatches++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("byte_out", want.byte_out, got.byte_out, stamp);
      compare_field("byte_present", 8'(want.byte_present), 8'(got.byte_present), stamp);
      compare_field("message_end", 8'(want.message_end), 8'(got.message_end), stamp);
      compare_field("status", 8'(want.status), 8'(got.status), stamp);
    endfunction
  endclass

endpackage

/* bench/testbench.sv */
// Testbench for base64_stream_decoder: directed and random encoded messages with
// random push gaps, pop stalls and long hold-offs; beats checked by a scoreboard.
// Depends on b64d_pkg, b64d_tb_pkg and the decoder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;
  import b64d_tb_pkg::*;

  typedef logic [7:0] char_q_t[$];

  localparam int ItemTarget = 370;
  localparam int HoldCycles = 120;
  localparam int StallLimit = 2000;
  localparam int TailCycles = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic full;
  in_t  data_i = '0;
  logic empty;
  logic pop    = 1'b0;
  out_t data_o;

  b64_decode_scoreboard sb = new();
  int items_sent     = 0;
  int burst_left     = 0;
  int hold_requests  = 0;
  int holds_done     = 0;
  int stalled_cycles = 0;

  base64_stream_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .data_i (data_i),
    .empty  (empty),
    .pop    (pop),
    .data_o (data_o)
  );

  always #5ns clk_i = ~clk_i;

  function automatic logic [7:0] symbol_char(input int idx);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    return (idx == 62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0D;
      default: return 8'h0A;
    endcase
  endfunction

  function automatic void add_symbol(ref char_q_t q, input logic [5:0] idx);
    if ($urandom_range(0, 7) == 0) q.push_back(blank_char());
    q.push_back(symbol_char(int'(idx)));
  endfunction

  function automatic char_q_t text_to_chars(input string s);
    char_q_t q;
    int i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic char_q_t random_message();
    char_q_t     chars;
    logic [7:0]  raw[$];
    logic [23:0] w;
    int          kind;
    int          n;
    int          i;
    int          pos;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      n = $urandom_range(1, 3);
      repeat (n) chars.push_back(blank_char());
    end else if (kind < 88) begin
      n = $urandom_range(1, 9);
      repeat (n) raw.push_back(8'($urandom_range(0, 255)));
      for (i = 0; i < n; i += 3) begin
        w = {raw[i], (i + 1 < n) ? raw[i + 1] : 8'h00, (i + 2 < n) ? raw[i + 2] : 8'h00};
        add_symbol(chars, w[23:18]);
        add_symbol(chars, w[17:12]);
        if (i + 1 < n) add_symbol(chars, w[11:6]);
        else chars.push_back(PadChar);
        if (i + 2 < n) add_symbol(chars, w[5:0]);
        else chars.push_back(PadChar);
      end
      if (kind < 20 && chars[$] != PadChar) chars.push_back(blank_char());
      if (kind >= 78) begin
        pos = $urandom_range(0, chars.size() - 1);
        case ($urandom_range(0, 2))
          0: void'(chars.pop_back());
          1: chars[pos] = 8'($urandom_range(0, 255));
          default: chars.insert(pos, PadChar);
        endcase
      end
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0, 1: chars.push_back(symbol_char($urandom_range(0, 63)));
          2: chars.push_back(PadChar);
          3: chars.push_back(blank_char());
          default: chars.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    return chars;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push   <= 1'b1;
    data_i <= '{char_in: c, is_final: fin};
    do @(posedge clk_i); while (full !== 1'b0);
    sb.note_char(data_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_message(input char_q_t chars);
    int i;
    for (i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_beat(data_o, $time);
  end

  initial begin : receiver
    int mode;
    int left;
    mode = 0;
    left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done++;
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(4, 40);
      end
      left--;
      case (mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 2) == 0);
        2: pop <= (left % 3 != 0);
        default: pop <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  initial begin : watchdog
    while (stalled_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) stalled_cycles = 0;
      else stalled_cycles++;
    end
    $display("base64_stream_decoder test failed");
    $finish;
  end

  initial begin : stimulus
    char_q_t chars;
    int      messages;
    messages = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_message(text_to_chars("+/9z"));
    send_message(text_to_chars("TQ=="));
    send_message(text_to_chars("//8="));
    send_message(text_to_chars("\t\r\n"));
    send_message(text_to_chars("AB= "));
    send_message(text_to_chars("ABC"));
    send_message(text_to_chars("A="));
    chars = '{8'h00, 8'hFF};
    send_message(chars);
    wait_drained();

    while (items_sent < ItemTarget) begin
      send_message(random_message());
      messages++;
      if (messages == 6 || messages == 30) hold_requests++;
      if (messages % 20 == 0) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("base64_stream_decoder test passed");
    end else begin
      $display("base64_stream_decoder test failed");
    end
    $finish;
  end

endmodule
